FILE: design/wiod_pkg.sv
`timescale 1ns / 1ps

package wiod_pkg;

    // Fixed field widths
    localparam int DATA_W    = 64;   // sample, debounced, init_value, bypass_mask
    localparam int CTRL_W    = 5;    // window_depth, vote_threshold, vote counters
    localparam int REG_IDX_W = 2;

    // Parameter defaults
    localparam int MAX_DEPTH_DEF = 16;
    localparam int IO_WIDTH_DEF  = 64;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_INIT_VALUE     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BYPASS_MASK    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_DEPTH   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_VOTE_THRESHOLD = 2'd3;

    localparam logic [CTRL_W-1:0] DEPTH_RST     = 5'd1;
    localparam logic [CTRL_W-1:0] THRESHOLD_RST = 5'd1;

    // Vote counter control
    typedef struct packed {
        logic load;   // start a new vote with this beat's change bits
        logic acc;    // add one history row
    } vote_ctl_t;

endpackage

FILE: design/wiod_hist_mem.sv
`timescale 1ns / 1ps

// Change history store: one write, one read per cycle, registered read.
// A row never written since the last clear reads as zero.
module wiod_hist_mem #(
    parameter int MAX_DEPTH = wiod_pkg::MAX_DEPTH_DEF,
    parameter int IO_WIDTH  = wiod_pkg::IO_WIDTH_DEF,
    parameter int AW        = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clr,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [IO_WIDTH-1:0] wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic [IO_WIDTH-1:0] rd_data
);

    logic [IO_WIDTH-1:0]  mem [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] row_vld_reg;
    logic [IO_WIDTH-1:0]  rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= row_vld_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
        end
        else if (clr)
        begin
            row_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            row_vld_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/wiod_vote_lanes.sv
`timescale 1ns / 1ps

// One vote counter per IO line.
module wiod_vote_lanes #(
    parameter int IO_WIDTH = wiod_pkg::IO_WIDTH_DEF
) (
    input  logic                        clk,
    input  wiod_pkg::vote_ctl_t         ctl,
    input  logic [IO_WIDTH-1:0]         first_row,
    input  logic [IO_WIDTH-1:0]         row,
    input  logic [wiod_pkg::CTRL_W-1:0] threshold,
    output logic [IO_WIDTH-1:0]         hit
);

    logic [wiod_pkg::CTRL_W-1:0] cnt_reg [IO_WIDTH];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < IO_WIDTH; i++)
        begin
            if (ctl.load)
            begin
                cnt_reg[i] <= wiod_pkg::CTRL_W'(first_row[i]);
            end
            else if (ctl.acc)
            begin
                cnt_reg[i] <= cnt_reg[i] + wiod_pkg::CTRL_W'(row[i]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < IO_WIDTH; i++)
        begin
            hit[i] = (cnt_reg[i] >= threshold);
        end
    end

endmodule

FILE: design/windowed_io_debounce_core.sv
`timescale 1ns / 1ps

// Windowed vote debouncer for up to 64 IO lines. Each sample beat is compared
// with the held output; the change bits of non-bypassed lines become the newest
// row of a change history kept in a small synchronous RAM (a circular buffer of
// MAX_DEPTH rows). A changed line toggles when at least vote_threshold of the
// newest window_depth rows show a change; its bit is then flipped in the
// newest window_depth-1 rows. Bypassed lines follow the sample directly.
// After the accept (D = effective depth) come one pass of D-1 RAM reads to
// count votes, a drain step, one read-modify-write pass of D-2 rows to flip
// toggled lines, a drain step, and the push of the new row. s_tready returns
// as the result is posted, so each new sample waits for the previous one to
// finish; the push waits while a full output register is stalled by m_tready.
// A new sample is taken while the previous result still waits on the output
// register. Writing init_value loads the output state and clears the
// history at once through per-row valid bits; no clearing pass is needed.
// Configuration writes are only allowed while no sample is in flight.
module windowed_io_debounce_core #(
    parameter int MAX_DEPTH = wiod_pkg::MAX_DEPTH_DEF,
    parameter int IO_WIDTH  = wiod_pkg::IO_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // sample beat
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wiod_pkg::DATA_W-1:0]    s_tdata,    // [63:0] sample
    // result beat
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [wiod_pkg::DATA_W-1:0]    m_tdata,    // [63:0] debounced
    // configuration writes
    input  logic                           cfg_we,
    input  logic [wiod_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [wiod_pkg::DATA_W-1:0]    cfg_wdata
);

    localparam int AW     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW     = wiod_pkg::CTRL_W;
    localparam int LAST_A = MAX_DEPTH - 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_COUNT  = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_FLIP   = 3'd3;
    localparam logic [2:0] S_FDRAIN = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // config registers
    logic [IO_WIDTH-1:0] bypass_reg;
    logic [CW-1:0]       depth_reg;
    logic [CW-1:0]       thr_reg;

    // datapath state
    logic [IO_WIDTH-1:0] held_reg, held_next;
    logic [IO_WIDTH-1:0] sample_reg;
    logic [IO_WIDTH-1:0] change_reg;
    logic [AW-1:0]       head_reg;      // address of the newest stored row (row 1 of the next vote)
    logic [AW-1:0]       ptr_reg;       // read pointer walking toward older rows
    logic [AW-1:0]       wb_addr_reg;   // address of the row now being read back
    logic [CW-1:0]       idx_reg;       // history row number of the next read
    logic [2:0]          state_reg, state_next;
    logic                rd_cnt_reg;    // read data this cycle belongs to the vote
    logic                rd_flip_reg;   // read data this cycle gets flipped
    logic                m_tvalid_reg;
    logic [IO_WIDTH-1:0] m_data_reg;

    logic [CW-1:0]       eff_depth;
    logic [CW-1:0]       eff_thr;
    logic [AW-1:0]       head_m1;
    logic [AW-1:0]       ptr_inc;
    logic [IO_WIDTH-1:0] sample_in;
    logic [IO_WIDTH-1:0] change_in;
    logic [IO_WIDTH-1:0] hit;
    logic [IO_WIDTH-1:0] toggle;
    logic [IO_WIDTH-1:0] row0_data;
    logic                accept;
    logic                out_free;
    logic                finish;
    logic                init_wr;

    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [IO_WIDTH-1:0] mem_wr_data;
    logic                mem_rd_en;
    logic [IO_WIDTH-1:0] mem_rd_data;
    wiod_pkg::vote_ctl_t vote_ctl;

    // window depth: zero acts as one, capped at MAX_DEPTH; threshold capped at depth
    always_comb
    begin
        if (depth_reg == '0)
        begin
            eff_depth = CW'(1);
        end
        else if (int'(depth_reg) > MAX_DEPTH)
        begin
            eff_depth = CW'(MAX_DEPTH);
        end
        else
        begin
            eff_depth = depth_reg;
        end
        eff_thr = (thr_reg > eff_depth) ? eff_depth : thr_reg;
    end

    assign head_m1   = (head_reg == '0) ? AW'(LAST_A) : head_reg - AW'(1);
    assign ptr_inc   = (ptr_reg == AW'(LAST_A)) ? '0 : ptr_reg + AW'(1);
    assign sample_in = s_tdata[IO_WIDTH-1:0];
    assign change_in = (sample_in ^ held_reg) & ~bypass_reg;
    assign init_wr   = cfg_we && (cfg_addr == wiod_pkg::REG_INIT_VALUE);

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == S_DONE) && out_free;

    assign toggle    = change_reg & hit;
    // new row 0 keeps the toggled lines only when it is outside the flip range
    assign row0_data = (eff_depth >= CW'(2)) ? (change_reg ^ toggle) : change_reg;
    assign held_next = ((held_reg ^ toggle) & ~bypass_reg) | (sample_reg & bypass_reg);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (eff_depth == CW'(1)) ? S_DRAIN : S_COUNT;
                end
            end
            S_COUNT:
            begin
                if (idx_reg == eff_depth - CW'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = (eff_depth >= CW'(3)) ? S_FLIP : S_FDRAIN;
            end
            S_FLIP:
            begin
                if (idx_reg == eff_depth - CW'(2))
                begin
                    state_next = S_FDRAIN;
                end
            end
            S_FDRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // RAM access: reads in both passes, write-back of flipped rows, then row 0 push
    assign mem_rd_en   = (state_reg == S_COUNT) || (state_reg == S_FLIP);
    assign mem_wr_en   = rd_flip_reg || finish;
    assign mem_wr_addr = rd_flip_reg ? wb_addr_reg : head_m1;
    assign mem_wr_data = rd_flip_reg ? (mem_rd_data ^ toggle) : row0_data;

    assign vote_ctl.load = accept;
    assign vote_ctl.acc  = rd_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_cnt_reg   <= 1'b0;
            rd_flip_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            head_reg     <= '0;
            held_reg     <= '0;
            bypass_reg   <= '0;
            depth_reg    <= wiod_pkg::DEPTH_RST;
            thr_reg      <= wiod_pkg::THRESHOLD_RST;
        end
        else
        begin
            state_reg   <= state_next;
            rd_cnt_reg  <= (state_reg == S_COUNT);
            rd_flip_reg <= (state_reg == S_FLIP);

            if (finish)
            begin
                m_tvalid_reg <= 1'b1;
                head_reg     <= head_m1;
                held_reg     <= held_next;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    wiod_pkg::REG_INIT_VALUE:     held_reg   <= cfg_wdata[IO_WIDTH-1:0];
                    wiod_pkg::REG_BYPASS_MASK:    bypass_reg <= cfg_wdata[IO_WIDTH-1:0];
                    wiod_pkg::REG_WINDOW_DEPTH:   depth_reg  <= cfg_wdata[CW-1:0];
                    wiod_pkg::REG_VOTE_THRESHOLD: thr_reg    <= cfg_wdata[CW-1:0];
                    default:                      ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        wb_addr_reg <= ptr_reg;
        if (accept)
        begin
            sample_reg <= sample_in;
            change_reg <= change_in;
            ptr_reg    <= head_reg;
            idx_reg    <= CW'(1);
        end
        else if (state_reg == S_DRAIN)
        begin
            ptr_reg <= head_reg;
            idx_reg <= CW'(1);
        end
        else if (mem_rd_en)
        begin
            ptr_reg <= ptr_inc;
            idx_reg <= idx_reg + CW'(1);
        end
        if (finish)
        begin
            m_data_reg <= held_next;
        end
    end

    wiod_hist_mem #(
        .MAX_DEPTH (MAX_DEPTH),
        .IO_WIDTH  (IO_WIDTH),
        .AW        (AW)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (init_wr),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (ptr_reg),
        .rd_data (mem_rd_data)
    );

    wiod_vote_lanes #(
        .IO_WIDTH (IO_WIDTH)
    ) u_vote (
        .clk       (clk),
        .ctl       (vote_ctl),
        .first_row (change_in),
        .row       (mem_rd_data),
        .threshold (eff_thr),
        .hit       (hit)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = wiod_pkg::DATA_W'(m_data_reg);

endmodule
